@@ src/bfpi_pkg.sv @@
package bfpi_pkg;

  localparam int unsigned POS_W        = 10;
  localparam int unsigned MACH_W       = 5;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned PTIME_W      = 16;
  localparam int unsigned IN_TIME_W    = 32;
  localparam int unsigned OUT_TIME_W   = 32;
  localparam int unsigned MACHINES_MIN = 2;

  // position reported when no row of a call was evaluated
  localparam logic [POS_W-1:0] BEST_POS_INIT = POS_W'(1);

  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [MACH_W-1:0]    machine;
    logic [IN_TIME_W-1:0] prev_departure;
    logic [IN_TIME_W-1:0] tail_time;
    logic [PTIME_W-1:0]   first_ptime;
    logic [PTIME_W-1:0]   second_ptime;
    logic                 skip_row;
    logic                 last_position;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]      best_position;
    logic [OUT_TIME_W-1:0] best_makespan;
  } out_word_t;

  // flags of one queued row
  typedef struct packed {
    logic             eval;
    logic             last;
    logic [POS_W-1:0] pos;
  } row_tag_t;

  // control of one machine step travelling down the evaluator
  typedef struct packed {
    logic             valid;
    logic             eval;
    logic             first;
    logic             last;
    logic             rowlast;
    logic [POS_W-1:0] pos;
  } tok_ctl_t;

endpackage

@@ src/bfpi_front.sv @@
module bfpi_front import bfpi_pkg::*; #(
  parameter int MAX_MACHINES = 32,
  parameter int TIME_WIDTH   = 32,
  localparam int MW          = $clog2(MAX_MACHINES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MW-1:0]         m_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  input  logic                  q_hold_i,
  output logic                  push_o,
  output row_tag_t              tag_o,
  output logic [TIME_WIDTH-1:0] row_e_o  [MAX_MACHINES],
  output logic [TIME_WIDTH-1:0] row_t_o  [MAX_MACHINES],
  output logic [PTIME_W-1:0]    row_p1_o [MAX_MACHINES],
  output logic [PTIME_W-1:0]    row_p2_o [MAX_MACHINES]
);

  localparam int AW = $clog2(MAX_MACHINES);
  localparam int CW = (MW > MACH_W) ? MW : MACH_W;

  logic [TIME_WIDTH-1:0] buf_e_q  [MAX_MACHINES];
  logic [TIME_WIDTH-1:0] buf_t_q  [MAX_MACHINES];
  logic [PTIME_W-1:0]    buf_p1_q [MAX_MACHINES];
  logic [PTIME_W-1:0]    buf_p2_q [MAX_MACHINES];

  logic [TIME_WIDTH-1:0] e_in;
  logic [TIME_WIDTH-1:0] t_in;
  logic [CW-1:0]         mach_x;
  logic [CW-1:0]         m_x;
  logic                  in_range;
  logic                  row_end;
  logic                  need_q;
  logic                  wr;
  logic [AW-1:0]         idx;

  // saturate input times to the internal time width
  if (TIME_WIDTH < IN_TIME_W) begin : g_clamp
    assign e_in = (|in_word_i.prev_departure[IN_TIME_W-1:TIME_WIDTH]) ? '1 :
                  in_word_i.prev_departure[TIME_WIDTH-1:0];
    assign t_in = (|in_word_i.tail_time[IN_TIME_W-1:TIME_WIDTH]) ? '1 :
                  in_word_i.tail_time[TIME_WIDTH-1:0];
  end else begin : g_wide
    assign e_in = TIME_WIDTH'(in_word_i.prev_departure);
    assign t_in = TIME_WIDTH'(in_word_i.tail_time);
  end

  assign mach_x   = CW'(in_word_i.machine);
  assign m_x      = CW'(m_i);
  assign in_range = mach_x < m_x;
  assign row_end  = in_range && (mach_x == m_x - CW'(1));
  assign need_q   = row_end && (!in_word_i.skip_row || in_word_i.last_position);
  assign idx      = AW'(in_word_i.machine);

  // hold a row end only while the queue still carries an earlier row it cannot free
  assign in_stall_o = in_valid_i && need_q && q_hold_i;
  assign wr         = in_valid_i && !in_stall_o && in_range;
  assign push_o     = wr && need_q;

  assign tag_o.eval = !in_word_i.skip_row;
  assign tag_o.last = in_word_i.last_position;
  assign tag_o.pos  = in_word_i.position;

  // present the row with this word merged in
  always_comb begin
    for (int i = 0; i < MAX_MACHINES; i++) begin
      if (wr && idx == AW'(i)) begin
        row_e_o[i]  = e_in;
        row_t_o[i]  = t_in;
        row_p1_o[i] = in_word_i.first_ptime;
        row_p2_o[i] = in_word_i.second_ptime;
      end else begin
        row_e_o[i]  = buf_e_q[i];
        row_t_o[i]  = buf_t_q[i];
        row_p1_o[i] = buf_p1_q[i];
        row_p2_o[i] = buf_p2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MACHINES; i++) begin
        buf_e_q[i]  <= '0;
        buf_t_q[i]  <= '0;
        buf_p1_q[i] <= '0;
        buf_p2_q[i] <= '0;
      end
    end else if (wr) begin
      buf_e_q[idx]  <= e_in;
      buf_t_q[idx]  <= t_in;
      buf_p1_q[idx] <= in_word_i.first_ptime;
      buf_p2_q[idx] <= in_word_i.second_ptime;
    end
  end

endmodule

@@ src/bfpi_rowq.sv @@
module bfpi_rowq import bfpi_pkg::*; #(
  parameter int MAX_MACHINES = 32,
  parameter int TIME_WIDTH   = 32,
  localparam int MW          = $clog2(MAX_MACHINES + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MW-1:0]         m_i,
  input  logic                  push_i,
  input  row_tag_t              tag_i,
  input  logic [TIME_WIDTH-1:0] row_e_i  [MAX_MACHINES],
  input  logic [TIME_WIDTH-1:0] row_t_i  [MAX_MACHINES],
  input  logic [PTIME_W-1:0]    row_p1_i [MAX_MACHINES],
  input  logic [PTIME_W-1:0]    row_p2_i [MAX_MACHINES],
  input  logic                  en_i,
  output logic                  q_hold_o,
  output tok_ctl_t              tok_o,
  output logic [TIME_WIDTH-1:0] e0_o,
  output logic [TIME_WIDTH-1:0] enext_o,
  output logic [PTIME_W-1:0]    p1_o,
  output logic [PTIME_W-1:0]    p2_o,
  output logic [TIME_WIDTH-1:0] t_o
);

  localparam int AW = $clog2(MAX_MACHINES);

  logic [TIME_WIDTH-1:0] sn_e_q  [MAX_MACHINES];
  logic [TIME_WIDTH-1:0] sn_t_q  [MAX_MACHINES];
  logic [PTIME_W-1:0]    sn_p1_q [MAX_MACHINES];
  logic [PTIME_W-1:0]    sn_p2_q [MAX_MACHINES];
  row_tag_t              tag_q;
  logic                  full_q;
  logic [AW-1:0]         k_q;
  logic [AW-1:0]         k_nx;
  logic                  step_last;
  logic                  free;

  tok_ctl_t              tok_q;
  logic [TIME_WIDTH-1:0] e0_q;
  logic [TIME_WIDTH-1:0] enext_q;
  logic [PTIME_W-1:0]    p1_q;
  logic [PTIME_W-1:0]    p2_q;
  logic [TIME_WIDTH-1:0] t_q;

  assign k_nx      = k_q + AW'(1);
  // a skipped row travels as a single marker step
  assign step_last = !tag_q.eval || (MW'(k_q) == m_i - MW'(1));
  assign free      = full_q && step_last && en_i;
  assign q_hold_o  = full_q && !free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      k_q    <= '0;
    end else if (push_i) begin
      full_q <= 1'b1;
      k_q    <= '0;
    end else if (full_q && en_i) begin
      if (step_last) begin
        full_q <= 1'b0;
        k_q    <= '0;
      end else begin
        k_q <= k_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sn_e_q  <= row_e_i;
      sn_t_q  <= row_t_i;
      sn_p1_q <= row_p1_i;
      sn_p2_q <= row_p2_i;
      tag_q   <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q.valid   <= full_q;
      tok_q.eval    <= tag_q.eval;
      tok_q.first   <= (k_q == '0);
      tok_q.last    <= step_last;
      tok_q.rowlast <= tag_q.last && step_last;
      tok_q.pos     <= tag_q.pos;
    end
  end

  // blocking departure of the next machine; none beyond the last one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q    <= sn_e_q[0];
      enext_q <= step_last ? '0 : sn_e_q[k_nx];
      p1_q    <= sn_p1_q[k_q];
      p2_q    <= sn_p2_q[k_q];
      t_q     <= sn_t_q[k_q];
    end
  end

  assign tok_o   = tok_q;
  assign e0_o    = e0_q;
  assign enext_o = enext_q;
  assign p1_o    = p1_q;
  assign p2_o    = p2_q;
  assign t_o     = t_q;

endmodule

@@ src/bfpi_eval.sv @@
module bfpi_eval import bfpi_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tok_ctl_t              tok_i,
  input  logic [TIME_WIDTH-1:0] e0_i,
  input  logic [TIME_WIDTH-1:0] enext_i,
  input  logic [PTIME_W-1:0]    p1_i,
  input  logic [PTIME_W-1:0]    p2_i,
  input  logic [TIME_WIDTH-1:0] t_i,
  output logic                  en_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  typedef logic [TIME_WIDTH-1:0] tm_t;

  function automatic tm_t sat_add(tm_t a, tm_t b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
  endfunction

  function automatic tm_t max2(tm_t a, tm_t b);
    return (a > b) ? a : b;
  endfunction

  logic en;

  // first departure row
  tm_t      f_acc_q;
  tm_t      f_val;
  tok_ctl_t s1_q;
  tm_t      s1_f_q;
  tm_t      s1_t_q;
  logic [PTIME_W-1:0] s1_p2_q;

  // second departure row, one machine behind the first
  tm_t      g_acc_q;
  tm_t      g_val;
  tm_t      h_f_q;
  tm_t      h_t_q;
  logic [PTIME_W-1:0] h_p2_q;
  logic     h_first_q;
  tok_ctl_t s2_q;
  tm_t      s2_g_q;
  tm_t      s2_t_q;
  tm_t      s2_tl_q;
  logic [PTIME_W-1:0] s2_p2l_q;

  // makespan terms
  tok_ctl_t s3_q;
  tm_t      s3_ta_q;
  tm_t      s3_gl_q;
  tm_t      s3_tl_q;

  tm_t      mk_acc_q;
  tm_t      partial;
  tok_ctl_t s4_q;
  tm_t      s4_part_q;
  tm_t      s4_tb_q;

  tok_ctl_t s5_q;
  tm_t      s5_mk_q;

  // best of the call
  tm_t              best_q;
  logic [POS_W-1:0] best_pos_q;
  logic             less;
  logic             emit;
  tm_t              new_best;
  logic [POS_W-1:0] new_pos;
  logic [OUT_TIME_W-1:0] best_out;

  logic      out_valid_q;
  out_word_t out_word_q;

  assign emit = s5_q.valid && s5_q.rowlast;
  assign en   = !(emit && out_valid_q && out_stall_i);
  assign en_o = en;

  // stage 1
  assign f_val = max2(sat_add(tok_i.first ? e0_i : f_acc_q, TIME_WIDTH'(p1_i)), enext_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_f_q  <= f_val;
      s1_p2_q <= p2_i;
      s1_t_q  <= t_i;
      if (tok_i.valid && tok_i.eval) begin
        f_acc_q <= f_val;
      end
    end
  end

  // stage 2: the first step of a row only primes the hold register
  assign g_val = max2(sat_add(h_first_q ? h_f_q : g_acc_q, TIME_WIDTH'(h_p2_q)), s1_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q.valid   <= s1_q.valid && (!s1_q.eval || !s1_q.first);
      s2_q.eval    <= s1_q.eval;
      s2_q.first   <= h_first_q;
      s2_q.last    <= s1_q.last;
      s2_q.rowlast <= s1_q.rowlast;
      s2_q.pos     <= s1_q.pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_g_q   <= g_val;
      s2_t_q   <= h_t_q;
      s2_p2l_q <= s1_p2_q;
      s2_tl_q  <= s1_t_q;
      if (s1_q.valid && s1_q.eval) begin
        h_f_q     <= s1_f_q;
        h_p2_q    <= s1_p2_q;
        h_t_q     <= s1_t_q;
        h_first_q <= s1_q.first;
        if (!s1_q.first) begin
          g_acc_q <= g_val;
        end
      end
    end
  end

  // stage 3: the last step also forms the final departure of the second job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ta_q <= sat_add(s2_g_q, s2_t_q);
      s3_gl_q <= sat_add(s2_g_q, TIME_WIDTH'(s2_p2l_q));
      s3_tl_q <= s2_tl_q;
    end
  end

  // stage 4: running row maximum; keep only row ends
  assign partial = max2(s3_q.first ? '0 : mk_acc_q, s3_ta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (en) begin
      s4_q.valid   <= s3_q.valid && (!s3_q.eval || s3_q.last);
      s4_q.eval    <= s3_q.eval;
      s4_q.first   <= s3_q.first;
      s4_q.last    <= s3_q.last;
      s4_q.rowlast <= s3_q.rowlast;
      s4_q.pos     <= s3_q.pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_part_q <= partial;
      s4_tb_q   <= sat_add(s3_gl_q, s3_tl_q);
      if (s3_q.valid && s3_q.eval) begin
        mk_acc_q <= partial;
      end
    end
  end

  // stage 5: row makespan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else if (en) begin
      s5_q <= s4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_mk_q <= max2(s4_part_q, s4_tb_q);
    end
  end

  // keep the first strict minimum
  assign less     = s5_q.eval && (s5_mk_q < best_q);
  assign new_best = less ? s5_mk_q : best_q;
  assign new_pos  = less ? s5_q.pos : best_pos_q;

  if (TIME_WIDTH > OUT_TIME_W) begin : g_out_clamp
    assign best_out = (|new_best[TIME_WIDTH-1:OUT_TIME_W]) ? '1 :
                      new_best[OUT_TIME_W-1:0];
  end else begin : g_out_ext
    assign best_out = OUT_TIME_W'(new_best);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '1;
      best_pos_q <= BEST_POS_INIT;
    end else if (en && s5_q.valid) begin
      if (emit) begin
        best_q     <= '1;
        best_pos_q <= BEST_POS_INIT;
      end else if (less) begin
        best_q     <= s5_mk_q;
        best_pos_q <= s5_q.pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && en) begin
      out_word_q.best_position <= new_pos;
      out_word_q.best_makespan <= best_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ src/blocking_flowshop_pair_insertion.sv @@
// Pair insertion evaluator for a blocking flow shop. Feed one word per machine element, machine
// count words per candidate position in ascending machine order; each word carries the
// preceding job's departure, the tail time and the two inserted jobs' processing times. The
// word of the last machine closes a row: unless skip_row is set, the row is evaluated into the
// two blocking departure rows and its makespan, and the first strict minimum is kept. After the
// row flagged last_position one result word gives the best position and makespan (position 1
// and all ones when nothing was evaluated) and the search rearms. A word whose machine index
// is at or above the machine count is dropped with its flags. Missing machines reuse whatever
// that machine last held. Times saturate at the internal time width. The block takes one word
// per cycle while no row end is stalled. A front row buffer merges words as they arrive; a
// one-row queue holds a closed row while the evaluator walks it, one machine per cycle while
// it is not paused, through an add and max pipeline. A row end is stalled only while the queue
// still holds a row that has not reached its last machine or whose last step is paused, so
// full rows of machine count words stream without stalls while the evaluator runs; rows
// shorter than that (missing elements, or a skipped final row sent alone) can stall.
// The evaluator pauses only while a result is ready behind a result still held on the output.
// Write machine_count only while idle; values below 2 act as 2, above MAX_MACHINES as
// MAX_MACHINES.
module blocking_flowshop_pair_insertion import bfpi_pkg::*; #(
  parameter int MAX_MACHINES = 32,
  parameter int TIME_WIDTH   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int MW = $clog2(MAX_MACHINES + 1);

  // effective machine count, clamped when written
  logic [MW-1:0] machine_count_q;
  logic [MW-1:0] machine_count_d;

  logic                  q_hold;
  logic                  push;
  row_tag_t              tag;
  logic [TIME_WIDTH-1:0] row_e  [MAX_MACHINES];
  logic [TIME_WIDTH-1:0] row_t  [MAX_MACHINES];
  logic [PTIME_W-1:0]    row_p1 [MAX_MACHINES];
  logic [PTIME_W-1:0]    row_p2 [MAX_MACHINES];

  logic                  en;
  tok_ctl_t              tok;
  logic [TIME_WIDTH-1:0] tok_e0;
  logic [TIME_WIDTH-1:0] tok_enext;
  logic [PTIME_W-1:0]    tok_p1;
  logic [PTIME_W-1:0]    tok_p2;
  logic [TIME_WIDTH-1:0] tok_t;

  always_comb begin
    if (32'(cfg_wdata_i) < MACHINES_MIN) begin
      machine_count_d = MW'(MACHINES_MIN);
    end else if (32'(cfg_wdata_i) > 32'(MAX_MACHINES)) begin
      machine_count_d = MW'(MAX_MACHINES);
    end else begin
      machine_count_d = MW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machine_count_q <= MW'(MACHINES_MIN);
    end else if (cfg_we_i) begin
      machine_count_q <= machine_count_d;
    end
  end

  // merge incoming words into the row buffer, close rows
  bfpi_front #(
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .m_i        (machine_count_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_hold_i   (q_hold),
    .push_o     (push),
    .tag_o      (tag),
    .row_e_o    (row_e),
    .row_t_o    (row_t),
    .row_p1_o   (row_p1),
    .row_p2_o   (row_p2)
  );

  // hold one closed row and walk it machine by machine
  bfpi_rowq #(
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_rowq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .m_i      (machine_count_q),
    .push_i   (push),
    .tag_i    (tag),
    .row_e_i  (row_e),
    .row_t_i  (row_t),
    .row_p1_i (row_p1),
    .row_p2_i (row_p2),
    .en_i     (en),
    .q_hold_o (q_hold),
    .tok_o    (tok),
    .e0_o     (tok_e0),
    .enext_o  (tok_enext),
    .p1_o     (tok_p1),
    .p2_o     (tok_p2),
    .t_o      (tok_t)
  );

  // departure rows, makespan, best of call, output register
  bfpi_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok),
    .e0_i        (tok_e0),
    .enext_i     (tok_enext),
    .p1_i        (tok_p1),
    .p2_i        (tok_p2),
    .t_i         (tok_t),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ src/bfpi_checker.sv @@
module bfpi_checker import bfpi_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // stall is raised only against an offered word
  a_stall_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_i)
    else $error("input stalled with no word offered");

  // only a row end that must be queued can be stalled
  a_stall_only_queued_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (!in_word_i.skip_row || in_word_i.last_position))
    else $error("stalled a skipped row that needs no evaluation");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o))
    else $error("result changed while stalled");

endmodule

bind blocking_flowshop_pair_insertion bfpi_checker u_bfpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfpi_pkg::*;

  // Matches the default MAX_MACHINES of the block.
  localparam int unsigned MACHINES_MAX     = 32;
  // Covers the path from closing word to result at the largest machine count, with slack on top.
  localparam int unsigned SETTLE_CYCLES    = MACHINES_MAX + 16;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned RANDOM_WORDS     = 280;
  localparam int unsigned STRAY_WORDS      = 100;
  localparam int unsigned FULL_RATE_WORDS  = 120;
  localparam int unsigned DRAIN_LIMIT      = 20000;

  typedef logic [IN_TIME_W-1:0] tval_t;

  // How far apart the random times of one call are spread.
  typedef enum int unsigned {
    SPAN_SMALL,
    SPAN_MID,
    SPAN_FULL,
    SPAN_TOP
  } span_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_word_t         in_word_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_word_t        out_word_o;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  // Knobs shared between the test tasks and the two handshake sides.
  bit tx_idle_on   = 1'b0;
  bit rx_idle_on   = 1'b0;
  bit hold_off_req = 1'b0;

  int unsigned words_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;

  // Shadow of the evaluator: merged row buffers, the running best of the
  // current call and the machine count register.
  tval_t               dep_row  [MACHINES_MAX];
  tval_t               tail_row [MACHINES_MAX];
  logic [PTIME_W-1:0]  p1_row   [MACHINES_MAX];
  logic [PTIME_W-1:0]  p2_row   [MACHINES_MAX];
  tval_t               best_span;
  logic [POS_W-1:0]    best_pos;
  logic [CNT_W-1:0]    count_shadow;

  // Best insertion results still owed by the block, oldest first.
  out_word_t best_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  blocking_flowshop_pair_insertion uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow evaluator
  // ---------------------------------------------------------------------------

  function automatic tval_t sat_sum(tval_t a, tval_t b);
    logic [IN_TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[IN_TIME_W] ? '1 : s[IN_TIME_W-1:0];
  endfunction

  function automatic tval_t later_of(tval_t a, tval_t b);
    return (a > b) ? a : b;
  endfunction

  // Clamp the register the way the block does: below 2 acts as 2, above the
  // machine limit acts as the limit.
  function automatic int unsigned eff_machines(logic [CNT_W-1:0] c);
    if (c < MACHINES_MIN) return MACHINES_MIN;
    if (c > MACHINES_MAX) return MACHINES_MAX;
    return c;
  endfunction

  // Walk the blocking departure row of the first job, then of the second,
  // and return the largest second departure plus tail.
  function automatic tval_t pair_makespan(int unsigned m);
    tval_t first_dep [MACHINES_MAX];
    tval_t run;
    tval_t blk;
    tval_t span;
    run = dep_row[0];
    for (int j = 0; j < m; j++) begin
      blk = (j + 1 < m) ? dep_row[j + 1] : '0;
      run = later_of(sat_sum(run, tval_t'(p1_row[j])), blk);
      first_dep[j] = run;
    end
    span = '0;
    run  = first_dep[0];
    for (int j = 0; j < m; j++) begin
      blk  = (j + 1 < m) ? first_dep[j + 1] : '0;
      run  = later_of(sat_sum(run, tval_t'(p2_row[j])), blk);
      span = later_of(span, sat_sum(run, tail_row[j]));
    end
    return span;
  endfunction

  function automatic void clear_insertion_state();
    for (int j = 0; j < MACHINES_MAX; j++) begin
      dep_row[j]  = '0;
      tail_row[j] = '0;
      p1_row[j]   = '0;
      p2_row[j]   = '0;
    end
    best_span    = '1;
    best_pos     = BEST_POS_INIT;
    count_shadow = CNT_W'(MACHINES_MIN);
  endfunction

  // Merge one accepted word; on the closing word of a row evaluate it, and on
  // the closing word of the final position queue the best insertion point.
  function automatic void absorb_element(in_word_t w);
    int unsigned m;
    tval_t       span;
    out_word_t   res;
    m = eff_machines(count_shadow);
    // Drop words beyond the machine count, flags and all.
    if (w.machine >= m) return;
    dep_row[w.machine]  = w.prev_departure;
    tail_row[w.machine] = w.tail_time;
    p1_row[w.machine]   = w.first_ptime;
    p2_row[w.machine]   = w.second_ptime;
    if (w.machine != m - 1) return;
    if (!w.skip_row) begin
      span = pair_makespan(m);
      // Strict compare: the earliest position wins a tie.
      if (span < best_span) begin
        best_span = span;
        best_pos  = w.position;
      end
    end
    if (!w.last_position) return;
    res.best_position = best_pos;
    res.best_makespan = best_span;
    best_q.push_back(res);
    best_span = '1;
    best_pos  = BEST_POS_INIT;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Predict on every word the block takes.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      absorb_element(in_word_i);
      words_taken++;
    end
  end

  // Compare every taken result with the oldest prediction, field by field.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (best_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result position %0d makespan %0h",
                                  out_word_o.best_position, out_word_o.best_makespan));
      end else begin
        want = best_q.pop_front();
        results_checked++;
        if (out_word_o.best_position !== want.best_position)
          report_mismatch($sformatf("best_position %0d, expected %0d",
                                    out_word_o.best_position, want.best_position));
        if (out_word_o.best_makespan !== want.best_makespan)
          report_mismatch($sformatf("best_makespan %0h, expected %0h",
                                    out_word_o.best_makespan, want.best_makespan));
      end
    end
  end

  // Result side: random stall bursts when enabled, and one long hold-off on
  // request, counted here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int unsigned burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one word and return at the edge that takes it. Valid stays high on
  // return, so the caller either offers the next word or drops valid in the
  // same step.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid, let the monitor absorb the last word, wait for every owed
  // result, then let a possibly skipped row still in the evaluator run out.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (best_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_machine_count(logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    count_shadow = value;
  endtask

  function automatic in_word_t element(logic [POS_W-1:0] pos, logic [MACH_W-1:0] mach,
                                       tval_t dep, tval_t tail,
                                       logic [PTIME_W-1:0] p1, logic [PTIME_W-1:0] p2,
                                       logic skip, logic last);
    in_word_t w;
    w.position       = pos;
    w.machine        = mach;
    w.prev_departure = dep;
    w.tail_time      = tail;
    w.first_ptime    = p1;
    w.second_ptime   = p2;
    w.skip_row       = skip;
    w.last_position  = last;
    return w;
  endfunction

  function automatic tval_t rand_time(span_e spread);
    case (spread)
      SPAN_SMALL: return tval_t'($urandom_range(0, 1000));
      SPAN_MID:   return tval_t'($urandom_range(0, 1 << 20));
      SPAN_FULL:  return tval_t'($urandom);
      default:    return '1 - tval_t'($urandom_range(0, 70000));
    endcase
  endfunction

  // Send one well-formed call: rows positions of machine count words each,
  // ascending machines, zero departures on the first row, zero tails on the
  // last, at most one skipped row. A ragged call also drops some non-closing
  // words and slips in stray words beyond the machine count.
  task automatic send_call(int unsigned rows, bit ragged);
    int unsigned m;
    int unsigned base;
    int unsigned skip_at;
    span_e       spread;
    bit          closing;
    bit          noisy_flags;
    in_word_t    w;
    m           = eff_machines(count_shadow);
    base        = $urandom_range(0, (1 << POS_W) - 1);
    skip_at     = $urandom_range(0, rows);
    spread      = span_e'($urandom_range(0, 3));
    noisy_flags = ragged || ($urandom_range(0, 1) == 1);
    for (int r = 0; r < rows; r++) begin
      for (int k = 0; k < m; k++) begin
        closing          = (k == m - 1);
        w.position       = POS_W'(base + r);
        w.machine        = MACH_W'(k);
        w.prev_departure = (r == 0) ? '0 : rand_time(spread);
        w.tail_time      = (r == rows - 1) ? '0 : rand_time(spread);
        // Keep processing times small against small departures so the
        // blocking term wins often.
        w.first_ptime    = (spread == SPAN_SMALL) ? PTIME_W'($urandom_range(0, 200))
                                                  : PTIME_W'($urandom);
        w.second_ptime   = (spread == SPAN_SMALL) ? PTIME_W'($urandom_range(0, 200))
                                                  : PTIME_W'($urandom);
        // Flags only count on the closing word; scramble them elsewhere.
        w.skip_row       = closing ? (r == skip_at) : (noisy_flags && $urandom_range(0, 1));
        w.last_position  = closing ? (r == rows - 1) : (noisy_flags && $urandom_range(0, 1));
        if (ragged && !closing && $urandom_range(0, 9) == 0) continue;
        send_word(w);
        if (ragged && m < MACHINES_MAX && $urandom_range(0, 11) == 0) begin
          w.machine       = MACH_W'($urandom_range(m, MACHINES_MAX - 1));
          w.skip_row      = $urandom_range(0, 1);
          w.last_position = $urandom_range(0, 1);
          send_word(w);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run at the reset machine count of two.
  task automatic test_directed_cases();
    // Tie between two equal rows: keep the earlier position.
    send_word(element(10'd0, 5'd0, '0, 32'd40, 16'd7, 16'd9, 1'b0, 1'b0));
    send_word(element(10'd0, 5'd1, '0, 32'd11, 16'd5, 16'd3, 1'b0, 1'b0));
    send_word(element(10'd1, 5'd0, '0, 32'd40, 16'd7, 16'd9, 1'b0, 1'b0));
    send_word(element(10'd1, 5'd1, '0, 32'd11, 16'd5, 16'd3, 1'b0, 1'b1));
    // Saturating row at the top position, then an all-zero row that wins.
    send_word(element(10'h3FF, 5'd0, '1, '1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_word(element(10'h3FF, 5'd1, '1, '1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_word(element(10'd5, 5'd0, '0, '0, '0, '0, 1'b0, 1'b0));
    send_word(element(10'd5, 5'd1, '0, '0, '0, '0, 1'b0, 1'b1));
    // A lone saturated row cannot beat the initial all-ones value.
    send_word(element(10'd7, 5'd0, '1, '1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_word(element(10'd7, 5'd1, '1, '1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    // Every row skipped: report the default position and all ones.
    send_word(element(10'd2, 5'd0, 32'd300, 32'd8, 16'd4, 16'd6, 1'b0, 1'b0));
    send_word(element(10'd2, 5'd1, 32'd310, 32'd9, 16'd5, 16'd2, 1'b1, 1'b0));
    send_word(element(10'd3, 5'd1, 32'd320, '0, 16'd1, 16'd1, 1'b1, 1'b1));
    // Word beyond the machine count with both flags set: must be dropped.
    send_word(element(10'd12, 5'd31, $urandom, $urandom, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    // Row closed by its last machine alone: machine 0 reuses what it held.
    send_word(element(10'd9, 5'd1, 32'd77, 32'd5, 16'd13, 16'd21, 1'b0, 1'b1));
    // Out of order: machine 1 closes a row on stale data, the flags on the
    // machine 0 word are ignored, and the next closing word ends the call.
    send_word(element(10'd4, 5'd1, 32'd1000, 32'd50, 16'd30, 16'd40, 1'b0, 1'b0));
    send_word(element(10'd4, 5'd0, 32'd900, 32'd60, 16'd70, 16'd80, 1'b1, 1'b1));
    send_word(element(10'd6, 5'd1, 32'd20, 32'd0, 16'd3, 16'd2, 1'b0, 1'b1));
  endtask

  // Walk the register through its extremes and out-of-range values.
  task automatic test_count_limits();
    logic [CNT_W-1:0] counts [7];
    counts = '{6'd0, 6'd63, 6'd1, 6'd33, 6'd32, 6'd2, 6'd5};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (counts[i]) begin
      settle();
      write_machine_count(counts[i]);
      send_call((eff_machines(counts[i]) > 8) ? 2 : 3, 1'b0);
    end
  endtask

  // Mostly small machine counts and short calls, with random idling switched
  // on and off per call so some stretches run back to back.
  task automatic test_random_calls();
    int unsigned start;
    int unsigned calls;
    int unsigned m;
    start = words_taken;
    calls = 0;
    while (words_taken - start < RANDOM_WORDS) begin
      if (calls % 4 == 0) begin
        settle();
        if ($urandom_range(0, 9) == 0) write_machine_count(CNT_W'($urandom_range(7, 63)));
        else write_machine_count(CNT_W'($urandom_range(2, 6)));
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      m = eff_machines(count_shadow);
      send_call((m > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6),
                $urandom_range(0, 3) == 0);
      calls++;
    end
  endtask

  // Unstructured words: random machines, flags and full-range times.
  task automatic test_stray_words();
    in_word_t w;
    settle();
    write_machine_count(CNT_W'(3));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (STRAY_WORDS) begin
      w.position       = POS_W'($urandom);
      w.machine        = ($urandom_range(0, 4) == 0) ? MACH_W'($urandom)
                                                     : MACH_W'($urandom_range(0, 3));
      w.prev_departure = $urandom;
      w.tail_time      = $urandom;
      w.first_ptime    = PTIME_W'($urandom);
      w.second_ptime   = PTIME_W'($urandom);
      w.skip_row       = $urandom_range(0, 1);
      w.last_position  = ($urandom_range(0, 3) == 0);
      send_word(w);
    end
  endtask

  // Hold the result side off for a long stretch while one-row calls keep
  // coming, so the block backs up into its input; then pause the sender
  // until every result is out.
  task automatic test_output_backpressure();
    settle();
    write_machine_count(CNT_W'(2));
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_call(1, 1'b0);
    settle();
  endtask

  // Close the run with no idling on either side.
  task automatic test_full_rate();
    int unsigned start;
    settle();
    write_machine_count(CNT_W'(4));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    start = words_taken;
    while (words_taken - start < FULL_RATE_WORDS) send_call($urandom_range(1, 5), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    int unsigned drain_wait;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    clear_insertion_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_count_limits();
    test_random_calls();
    test_stray_words();
    test_output_backpressure();
    test_full_rate();

    // Drain: wait for owed results within a bound, then let the pipe empty.
    in_valid_i <= 1'b0;
    drain_wait = 0;
    while (best_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (best_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", best_q.size()));

    $display("Covered %0d words and %0d results over machine counts 0 to 63 written,",
             words_taken, results_checked);
    $display("with ragged, skipped and saturated rows and one %0d-cycle output hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
